### design/tts_pkg.sv
// Shared types, constants and the segment table of the temperature display writer.
`timescale 1ns / 1ps

package tts_pkg;

   localparam int NUM_DIGITS = 3;
   localparam int POS_WIDTH  = 2;
   localparam int TEMP_WIDTH = 15;
   localparam int MAG_WIDTH  = 14;

   localparam logic [MAG_WIDTH-1:0] MAG_LIMIT = 14'd9999;
   localparam logic [MAG_WIDTH-1:0] MAG_TENS  = 14'd1000;

   localparam logic [7:0] GRID_BASE = 8'hC0;
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_POINT = 8'h80;

   localparam logic [POS_WIDTH-1:0] LAST_POS = 2'd2;

   // Segment codes of the three display positions, position 0 in the low byte.
   typedef logic [NUM_DIGITS-1:0][7:0] codes_type;

   // Segment pattern of one decimal digit; codes above nine never occur.
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] pattern;
      unique case (digit)
         4'd0:    pattern = 8'h3f;
         4'd1:    pattern = 8'h06;
         4'd2:    pattern = 8'h5b;
         4'd3:    pattern = 8'h4f;
         4'd4:    pattern = 8'h66;
         4'd5:    pattern = 8'h6d;
         4'd6:    pattern = 8'h7d;
         4'd7:    pattern = 8'h07;
         4'd8:    pattern = 8'h7f;
         4'd9:    pattern = 8'h6f;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

endpackage

### design/temperature_to_seven_segment.sv
// Top level of the temperature to seven-segment display writer.
`timescale 1ns / 1ps

// The first digit write of an item passes the input register, the holding register and the
// output register on its way to the result ports; the other two follow in position order.
// The single result port carries three digit writes per item; an item is taken while the
// previous one is still written.
// Reset clears the input and holding valid flags and the strobe; no result leaves the block
// until an item has been accepted. The receiver takes every write in the cycle it is shown.
module temperature_to_seven_segment (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tts_pkg::TEMP_WIDTH-1:0] req_temp_centi,
   output logic                           rsp_strobe,
   output logic [7:0]                     rsp_grid_address,
   output logic [7:0]                     rsp_segment_code,
   output logic                           rsp_last_digit
);
   import tts_pkg::*;

   // Input register: one item waits here while the previous one is still being written.
   logic                  in_valid_ff, in_valid_in;
   logic [TEMP_WIDTH-1:0] in_temp_ff, in_temp_in;
   logic                  accept;
   logic                  move;
   logic                  ser_ready;
   codes_type             codes;

   always_comb begin
      // The input register frees up whenever the holding register takes its item,
      // so a new item may enter in the very cycle the old one moves on.
      move        = in_valid_ff && ser_ready;
      busy        = in_valid_ff && !ser_ready;
      accept      = start && !busy;
      in_valid_in = accept || (in_valid_ff && !move);
      in_temp_in  = accept ? req_temp_centi : in_temp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_temp_ff <= in_temp_in;
   end

   // Sign handling, saturation, decimal digits and segment lookup in one pass.
   tts_convert u_convert (
      .temp_centi (in_temp_ff),
      .codes      (codes)
   );

   // Holds the three codes and writes them out one per cycle, position 0 first.
   tts_serializer u_serializer (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (in_valid_ff),
      .load_codes       (codes),
      .load_ready       (ser_ready),
      .rsp_strobe       (rsp_strobe),
      .rsp_grid_address (rsp_grid_address),
      .rsp_segment_code (rsp_segment_code),
      .rsp_last_digit   (rsp_last_digit)
   );

endmodule

### design/tts_convert.sv
// Conversion of a signed temperature into the three segment codes of the display.
`timescale 1ns / 1ps

module tts_convert (
   input  logic [tts_pkg::TEMP_WIDTH-1:0] temp_centi,
   output tts_pkg::codes_type             codes
);
   import tts_pkg::*;

   logic                  neg;
   logic [TEMP_WIDTH-1:0] abs_val;
   logic [MAG_WIDTH-1:0]  mag;
   logic [29:0]           prod_10;
   logic [26:0]           prod_100;
   logic [27:0]           prod_1000;
   logic [9:0]            q_10;
   logic [6:0]            q_100;
   logic [3:0]            q_1000;
   logic [MAG_WIDTH-1:0]  rem_units;
   logic [9:0]            rem_tens;
   logic [6:0]            rem_hundreds;
   logic [3:0]            d_hundredths;
   logic [3:0]            d_tenths;
   logic [3:0]            d_units;
   logic [3:0]            d_tens;

   always_comb begin
      neg     = temp_centi[TEMP_WIDTH-1];
      // The most negative code turns into 16384, which still fits unsigned.
      abs_val = neg ? (TEMP_WIDTH'(0) - temp_centi) : temp_centi;
      mag     = (abs_val > TEMP_WIDTH'(MAG_LIMIT)) ? MAG_LIMIT : abs_val[MAG_WIDTH-1:0];

      // Division by 10, 100 and 1000 through scaled reciprocals, exact below 10000.
      prod_10   = 30'(mag) * 30'd52429;
      prod_100  = 27'(mag) * 27'd5243;
      prod_1000 = 28'(mag) * 28'd8389;
      q_10      = prod_10[28:19];
      q_100     = prod_100[25:19];
      q_1000    = prod_1000[26:23];

      rem_units    = mag - MAG_WIDTH'(q_10) * MAG_WIDTH'(10);
      rem_tens     = q_10 - 10'(q_100) * 10'd10;
      rem_hundreds = q_100 - 7'(q_1000) * 7'd10;
      d_hundredths = rem_units[3:0];
      d_tenths     = rem_tens[3:0];
      d_units      = rem_hundreds[3:0];
      d_tens       = q_1000;

      if (neg) begin
         codes[0] = SEG_MINUS;
         if (mag < MAG_TENS) begin
            codes[1] = seg_of(d_units) | SEG_POINT;
            codes[2] = seg_of(d_tenths);
         end else begin
            codes[1] = seg_of(d_tens);
            codes[2] = seg_of(d_units);
         end
      end else begin
         if (mag < MAG_TENS) begin
            codes[0] = seg_of(d_units) | SEG_POINT;
            codes[1] = seg_of(d_tenths);
            codes[2] = seg_of(d_hundredths);
         end else begin
            codes[0] = seg_of(d_tens);
            codes[1] = seg_of(d_units) | SEG_POINT;
            codes[2] = seg_of(d_tenths);
         end
      end
   end

endmodule

### design/tts_serializer.sv
// Holding register for one item's segment codes and the digit write sequencer.
`timescale 1ns / 1ps

module tts_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  tts_pkg::codes_type load_codes,
   output logic              load_ready,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_grid_address,
   output logic [7:0]        rsp_segment_code,
   output logic              rsp_last_digit
);
   import tts_pkg::*;

   logic                 hold_valid_ff, hold_valid_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   codes_type            codes_ff, codes_in;
   logic                 strobe_ff, strobe_in;
   logic [7:0]           addr_ff, addr_in;
   logic [7:0]           code_ff, code_in;
   logic                 last_ff, last_in;
   logic                 done;

   always_comb begin
      done          = hold_valid_ff && (pos_ff == LAST_POS);
      load_ready    = !hold_valid_ff || done;
      hold_valid_in = hold_valid_ff;
      pos_in        = pos_ff;
      codes_in      = codes_ff;
      if (load_valid && load_ready) begin
         hold_valid_in = 1'b1;
         pos_in        = '0;
         codes_in      = load_codes;
      end else if (done) begin
         hold_valid_in = 1'b0;
      end else if (hold_valid_ff) begin
         pos_in = pos_ff + POS_WIDTH'(1);
      end

      strobe_in = hold_valid_ff;
      addr_in   = GRID_BASE + {5'd0, pos_ff, 1'b0};
      code_in   = codes_ff[pos_ff];
      last_in   = (pos_ff == LAST_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         strobe_ff     <= strobe_in;
      end
      pos_ff   <= pos_in;
      codes_ff <= codes_in;
      addr_ff  <= addr_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_grid_address = addr_ff;
   assign rsp_segment_code = code_ff;
   assign rsp_last_digit   = last_ff;

endmodule

### tb/tb.sv
// Self-checking testbench of the temperature to seven-segment display writer.
`timescale 1ns / 1ps

module tb;

   import tts_pkg::*;

   // One expected digit write, as it should appear on the result ports.
   typedef struct packed {
      logic [7:0] grid_address;
      logic [7:0] segment_code;
      logic       last_digit;
   } digit_write_type;

   // One row of the directed table. When has_codes is set, the three segment codes are typed
   // in by hand; otherwise they come from the display predictor below.
   typedef struct packed {
      logic [TEMP_WIDTH-1:0] temp_centi;
      logic                  has_codes;
      codes_type             codes;
   } temp_row_type;

   localparam int NUM_ROWS      = 25;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [TEMP_WIDTH-1:0] req_temp_centi;
   logic                  rsp_strobe;
   logic [7:0]            rsp_grid_address;
   logic [7:0]            rsp_segment_code;
   logic                  rsp_last_digit;

   // Digit writes the block still owes, oldest first.
   digit_write_type pending_writes[$];
   int              error_count;
   int              cycle_count;

   // The predictor keeps its own segment table for the ten decimal digits.
   logic [7:0] digit_pattern [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                      8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

   temperature_to_seven_segment dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_temp_centi   (req_temp_centi),
      .rsp_strobe       (rsp_strobe),
      .rsp_grid_address (rsp_grid_address),
      .rsp_segment_code (rsp_segment_code),
      .rsp_last_digit   (rsp_last_digit)
   );

   // A 20 ns clock, high for half the period and low for the other half.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out the three segment codes that a temperature should light up. The sign is the
   // top bit of the 15-bit input; the magnitude saturates at 99.99 degrees and every digit
   // is truncated toward zero.
   function automatic codes_type display_codes(input logic [TEMP_WIDTH-1:0] temp_centi);
      logic      negative;
      int        magnitude;
      codes_type codes;
      negative  = temp_centi[TEMP_WIDTH-1];
      magnitude = negative ? (32768 - int'(temp_centi)) : int'(temp_centi);
      if (magnitude > int'(MAG_LIMIT)) begin
         magnitude = int'(MAG_LIMIT);
      end
      if (negative) begin
         codes[0] = SEG_MINUS;
         if (magnitude < int'(MAG_TENS)) begin
            // Minus sign, units with the point, tenths.
            codes[1] = digit_pattern[(magnitude / 100) % 10] | SEG_POINT;
            codes[2] = digit_pattern[(magnitude / 10) % 10];
         end else begin
            // Minus sign, tens, units; no room left for a fraction.
            codes[1] = digit_pattern[(magnitude / 1000) % 10];
            codes[2] = digit_pattern[(magnitude / 100) % 10];
         end
      end else if (magnitude < int'(MAG_TENS)) begin
         // Units with the point, tenths, hundredths.
         codes[0] = digit_pattern[(magnitude / 100) % 10] | SEG_POINT;
         codes[1] = digit_pattern[(magnitude / 10) % 10];
         codes[2] = digit_pattern[magnitude % 10];
      end else begin
         // Tens, units with the point, tenths.
         codes[0] = digit_pattern[(magnitude / 1000) % 10];
         codes[1] = digit_pattern[(magnitude / 100) % 10] | SEG_POINT;
         codes[2] = digit_pattern[(magnitude / 10) % 10];
      end
      return codes;
   endfunction

   // Queues the three digit writes of one item, positions 0, 1 and 2 in that order.
   task automatic queue_digit_writes(input codes_type codes);
      digit_write_type digit_write;
      for (int pos = 0; pos < NUM_DIGITS; pos++) begin
         digit_write.grid_address = GRID_BASE + 8'(2 * pos);
         digit_write.segment_code = codes[pos];
         digit_write.last_digit   = (pos == int'(LAST_POS));
         pending_writes.push_back(digit_write);
      end
   endtask

   // Offers one temperature and holds it until the block takes it. Start is raised just
   // after a rising edge, and the item counts as taken at the first edge where busy is low.
   // Any idle gap follows acceptance, so start is never lowered and raised in one step.
   task automatic send_temperature(input logic [TEMP_WIDTH-1:0] temp_centi,
                                   input logic has_codes, input codes_type typed_codes,
                                   input int idle_cycles);
      start          <= 1'b1;
      req_temp_centi <= temp_centi;
      do begin
         @(posedge clock);
      end while (busy);
      queue_digit_writes(has_codes ? typed_codes : display_codes(temp_centi));
      if (idle_cycles > 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
   endtask

   // Roughly one item in four is followed by a short pause on the sending side.
   function automatic int pick_idle_cycles();
      if ($urandom_range(99) < 24) begin
         return $urandom_range(1, 4);
      end
      return 0;
   endfunction

   // Random temperatures: mostly inside the display range, some hugging the points where
   // the layout changes, and some from the whole 15-bit range to exercise saturation.
   function automatic logic [TEMP_WIDTH-1:0] pick_temperature();
      int choice;
      int value;
      choice = $urandom_range(99);
      if (choice < 70) begin
         value = int'($urandom_range(19998)) - 9999;
      end else if (choice < 85) begin
         case ($urandom_range(3))
            0:       value = 1000 + int'($urandom_range(6)) - 3;
            1:       value = -1000 + int'($urandom_range(6)) - 3;
            2:       value = 9999 + int'($urandom_range(6)) - 3;
            default: value = int'($urandom_range(6)) - 3;
         endcase
      end else begin
         value = int'($urandom_range(32767));
      end
      return TEMP_WIDTH'(value);
   endfunction

   // The receiver takes every digit write in the cycle it is shown, so each strobe is
   // checked on the edge that ends it against the oldest write still owed.
   always @(posedge clock) begin
      digit_write_type owed;
      if (!reset && rsp_strobe) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected digit write: grid_address %h segment_code %h last_digit %b",
                   rsp_grid_address, rsp_segment_code, rsp_last_digit);
            error_count++;
         end else begin
            owed = pending_writes.pop_front();
            if (rsp_grid_address !== owed.grid_address) begin
               $error("grid_address: expected %h, actual %h",
                      owed.grid_address, rsp_grid_address);
               error_count++;
            end
            if (rsp_segment_code !== owed.segment_code) begin
               $error("segment_code: expected %h, actual %h",
                      owed.segment_code, rsp_segment_code);
               error_count++;
            end
            if (rsp_last_digit !== owed.last_digit) begin
               $error("last_digit: expected %b, actual %b",
                      owed.last_digit, rsp_last_digit);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost digit write ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("temperature_to_seven_segment verification failed");
         $finish;
      end
   end

   initial begin
      temp_row_type directed_rows [NUM_ROWS];
      int           idle_cycles;

      // Directed table. Codes are listed as {position 2, position 1, position 0}.
      directed_rows = '{
         // Zero counts as non-negative and shows 0.00.
         '{15'sd0,      1'b1, {8'h3f, 8'h3f, 8'hbf}},
         '{15'sd1,      1'b0, '0},
         // One hundredth below zero is already negative: -0.0.
         '{-15'sd1,     1'b1, {8'h3f, 8'hbf, 8'h40}},
         // Both sides of the 10.00 layout switch, positive and negative.
         '{15'sd999,    1'b1, {8'h6f, 8'h6f, 8'hef}},
         '{15'sd1000,   1'b1, {8'h3f, 8'hbf, 8'h06}},
         '{-15'sd999,   1'b1, {8'h6f, 8'hef, 8'h40}},
         '{-15'sd1000,  1'b1, {8'h3f, 8'h06, 8'h40}},
         // Ends of the display range.
         '{15'sd9999,   1'b1, {8'h6f, 8'hef, 8'h6f}},
         '{-15'sd9999,  1'b1, {8'h6f, 8'h6f, 8'h40}},
         // Out of range values saturate to 99.99 and keep their sign, up to the
         // ends of the 15-bit field.
         '{15'sd10000,  1'b1, {8'h6f, 8'hef, 8'h6f}},
         '{-15'sd10000, 1'b1, {8'h6f, 8'h6f, 8'h40}},
         '{15'h3fff,    1'b1, {8'h6f, 8'hef, 8'h6f}},
         '{15'h4000,    1'b1, {8'h6f, 8'h6f, 8'h40}},
         '{15'sd1234,   1'b0, '0},
         '{-15'sd5678,  1'b0, '0},
         '{15'sd9998,   1'b0, '0},
         '{15'sd4567,   1'b0, '0},
         '{-15'sd123,   1'b0, '0},
         '{15'sd8901,   1'b0, '0},
         '{15'sd100,    1'b0, '0},
         '{-15'sd100,   1'b0, '0},
         '{15'sd5,      1'b0, '0},
         '{-15'sd55,    1'b0, '0},
         '{15'sd10,     1'b0, '0},
         '{15'sd2500,   1'b0, '0}
      };

      error_count    = 0;
      cycle_count    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_temp_centi = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items, each with the usual random idling behind it.
      for (int row = 0; row < NUM_ROWS; row++) begin
         send_temperature(directed_rows[row].temp_centi, directed_rows[row].has_codes,
                          directed_rows[row].codes, pick_idle_cycles());
      end

      // Random items. Items 100 to 179 go back to back so the block sees a long run at
      // full rate; before item 150 the sender holds off until every write has been seen.
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == 150) begin
            start <= 1'b0;
            while (pending_writes.size() != 0) @(posedge clock);
         end
         idle_cycles = (item >= 100 && item < 180) ? 0 : pick_idle_cycles();
         send_temperature(pick_temperature(), 1'b0, '0, idle_cycles);
      end
      start <= 1'b0;

      // Drain the digit writes still in flight, then give the block a few more cycles
      // in case it produces anything it should not.
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_writes.size() == 0) begin
         $display("temperature_to_seven_segment verification clean");
      end else begin
         $display("temperature_to_seven_segment verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/tts_pkg.sv
design/tts_convert.sv
design/tts_serializer.sv
design/temperature_to_seven_segment.sv
tb/tb.sv
